// File: rtl/ctcg_pkg.sv
package ctcg_pkg;

    localparam int IDX_W  = 15;
    localparam int PROB_W = 16;
    localparam int CNT_W  = 11;
    localparam int SUM_W  = 26;
    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(SUM_W);

    localparam int CLASS_LIMIT = 32768;
    localparam int COUNT_CAP   = 1024;

    localparam logic KIND_SYMBOL  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef logic [SUM_W-1:0] t_word;

    typedef struct packed {
        logic  borrow;
        t_word diff;
    } t_sub_res;

endpackage

// File: rtl/ctcg_if.sv
interface ctcg_in_if;
    import ctcg_pkg::*;
    logic              valid;
    logic              ready;
    logic [PROB_W-1:0] class_prob;
    logic              row_end;
    logic              seq_end;

    modport source (output valid, class_prob, row_end, seq_end, input ready);
    modport sink   (input valid, class_prob, row_end, seq_end, output ready);
endinterface

interface ctcg_out_if;
    import ctcg_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [IDX_W-1:0]  symbol_index;
    logic [PROB_W-1:0] symbol_prob;
    logic [PROB_W-1:0] mean_conf;
    logic [CNT_W-1:0]  symbol_count;
    logic              last;

    modport source (output valid, kind, symbol_index, symbol_prob, mean_conf,
                    symbol_count, last, input ready);
    modport sink   (input valid, kind, symbol_index, symbol_prob, mean_conf,
                    symbol_count, last, output ready);
endinterface

// File: rtl/ctcg_sub_unit.sv
module ctcg_sub_unit
    import ctcg_pkg::*;
(
    input  t_word    i_a,
    input  t_word    i_b,
    output t_sub_res o_res
);

    // a - b with borrow out; borrow set means b > a
    assign o_res = {1'b0, i_a} - {1'b0, i_b};

endmodule

// File: rtl/ctc_greedy_decoder_unit.sv
// CTC greedy decoder.
// Input channel i_in carries one class probability (Q0.16) per transaction,
// with row_end on the last class of a time step and seq_end (with row_end)
// on the last step of a sequence. Output channel o_out carries symbol
// results (kind 0) and one end-of-sequence summary (kind 1) with the
// emitted count, capped at 1024, and the truncated mean probability; last
// marks the final result of the input transaction that caused it.
// i_cfg_we / i_cfg_wdata write blank_index; write it only while idle.
// Sequencing: a class that does not end a row passes accept (S_IDLE) and compare (S_CMP).
// A row end adds the row decision (S_ROW). A sequence end then computes the mean
// by restoring division (S_DIV), one quotient bit per cycle on the same
// shared subtractor that performs the argmax compare, and then loads the
// summary (S_SUM). Input is taken only while the sequencer is idle.
// A single output register holds a result; the block accepts the next
// input while it waits, and stalls only when a new result must be loaded
// and the receiver has not taken the pending one.
// Reset (synchronous, active low) clears the row and sequence state and
// sets blank_index to zero; a pending result is dropped.
module ctc_greedy_decoder_unit
    import ctcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    ctcg_in_if.sink          i_in,
    ctcg_out_if.source       o_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_ROW,
        S_DIV,
        S_SUM
    } t_state;

    t_state r_state;

    // captured input transaction
    logic [PROB_W-1:0] r_prob;
    logic              r_row_end;
    logic              r_seq_end;

    // row and sequence state
    logic [IDX_W-1:0]  r_blank;
    logic [IDX_W-1:0]  r_cls;
    logic [IDX_W-1:0]  r_best_idx;
    logic [PROB_W-1:0] r_best_prob;
    logic [IDX_W-1:0]  r_prev_idx;
    logic              r_prev_valid;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;

    // divider state
    logic [SUM_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    // output register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [IDX_W-1:0]  r_out_idx;
    logic [PROB_W-1:0] r_out_prob;
    logic [PROB_W-1:0] r_out_mean;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    t_word    sub_a;
    t_word    sub_b;
    t_sub_res sub_res;

    logic             out_free;
    logic             out_load;
    logic             emit;
    logic             cnt_room;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic [REM_W-1:0] trial;

    ctcg_sub_unit u_sub (
        .i_a   (sub_a),
        .i_b   (sub_b),
        .o_res (sub_res)
    );

    // Select operands of the shared subtractor: argmax compare or divide step.
    assign trial = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};

    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = SUM_W'(trial);
            sub_b = SUM_W'(r_cnt);
        end else begin
            sub_a = SUM_W'(r_best_prob);
            sub_b = SUM_W'(r_prob);
        end
    end

    assign out_free = !r_out_valid || o_out.ready;

    // Row end decision: skip blank and repeats of the previous row's best.
    assign emit     = (r_best_idx != r_blank) &&
                      !(r_prev_valid && (r_best_idx == r_prev_idx));
    assign cnt_room = (r_cnt < CNT_W'(COUNT_CAP));
    assign n_sum    = (emit && cnt_room) ? (r_sum + SUM_W'(r_best_prob)) : r_sum;
    assign n_cnt    = (emit && cnt_room) ? (r_cnt + CNT_W'(1)) : r_cnt;

    // A new result enters the output register this cycle.
    assign out_load = ((r_state == S_ROW) && emit && out_free) ||
                      ((r_state == S_SUM) && out_free);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out_kind;
    assign o_out.symbol_index = r_out_idx;
    assign o_out.symbol_prob  = r_out_prob;
    assign o_out.mean_conf    = r_out_mean;
    assign o_out.symbol_count = r_out_cnt;
    assign o_out.last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_blank      <= '0;
            r_cls        <= '0;
            r_best_idx   <= '0;
            r_best_prob  <= '0;
            r_prev_idx   <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blank <= i_cfg_wdata;
            end

            // Drop the pending result once the receiver takes it, unless a new one loads.
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_prob    <= i_in.class_prob;
                        r_row_end <= i_in.row_end;
                        r_seq_end <= i_in.seq_end;
                        r_state   <= S_CMP;
                    end
                end

                S_CMP: begin
                    // First class of a row always wins; later only if strictly greater.
                    if ((r_cls == '0) || sub_res.borrow) begin
                        r_best_prob <= r_prob;
                        r_best_idx  <= r_cls;
                    end
                    if (r_cls != IDX_W'(CLASS_LIMIT - 1)) begin
                        r_cls <= r_cls + IDX_W'(1);
                    end
                    r_state <= r_row_end ? S_ROW : S_IDLE;
                end

                S_ROW: begin
                    // Hold here while a symbol must go out and the slot is busy.
                    if (!emit || out_free) begin
                        if (emit) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= KIND_SYMBOL;
                            r_out_idx   <= r_best_idx;
                            r_out_prob  <= r_best_prob;
                            r_out_mean  <= '0;
                            r_out_cnt   <= '0;
                            r_out_last  <= !r_seq_end;
                        end
                        r_sum        <= n_sum;
                        r_cnt        <= n_cnt;
                        r_prev_idx   <= r_best_idx;
                        r_prev_valid <= 1'b1;
                        r_cls        <= '0;
                        r_best_idx   <= '0;
                        r_best_prob  <= '0;
                        if (r_seq_end) begin
                            r_quo   <= n_sum;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_DIV: begin
                    // One restoring step: shift in a dividend bit, try subtract.
                    if (sub_res.borrow) begin
                        r_rem <= trial;
                    end else begin
                        r_rem <= sub_res.diff[REM_W-1:0];
                    end
                    r_quo <= {r_quo[SUM_W-2:0], !sub_res.borrow};
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_SUM;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end

                S_SUM: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= KIND_SUMMARY;
                        r_out_idx    <= '0;
                        r_out_prob   <= '0;
                        r_out_mean   <= (r_cnt == '0) ? '0 : r_quo[PROB_W-1:0];
                        r_out_cnt    <= r_cnt;
                        r_out_last   <= 1'b1;
                        r_sum        <= '0;
                        r_cnt        <= '0;
                        r_prev_idx   <= '0;
                        r_prev_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: tb/sv/ctcg_decode_checker.sv
`timescale 1ns / 1ps

module ctcg_decode_checker
    import ctcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    ctcg_in_if               i_in_mon,
    ctcg_out_if              i_out_mon,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  symbol_index;
        logic [PROB_W-1:0] symbol_prob;
        logic [PROB_W-1:0] mean_conf;
        logic [CNT_W-1:0]  symbol_count;
        logic              last;
    } t_decoded;

    t_decoded decoded_q[$];

    logic [IDX_W-1:0]  blank_idx;
    logic [IDX_W-1:0]  class_pos;
    logic [IDX_W-1:0]  lead_idx;
    logic [PROB_W-1:0] lead_prob;
    logic [IDX_W-1:0]  prev_idx;
    logic              prev_seen;
    logic [SUM_W-1:0]  prob_sum;
    logic [CNT_W-1:0]  sym_count;
    int                fails = 0;

    assign o_fail_count = fails;

    // Advance the decoder state by one class and queue the results it causes.
    task automatic decode_class(input logic [PROB_W-1:0] prob, input logic row_done,
                                input logic seq_done);
        t_decoded made [2];
        int       n;
        int       k;
        n = 0;
        made[0] = '0;
        made[1] = '0;
        if (class_pos == '0 || prob > lead_prob) begin
            lead_prob = prob;
            lead_idx  = class_pos;
        end
        if (class_pos < CLASS_LIMIT - 1)
            class_pos++;
        if (row_done) begin
            if (lead_idx != blank_idx && !(prev_seen && lead_idx == prev_idx)) begin
                made[n].kind         = KIND_SYMBOL;
                made[n].symbol_index = lead_idx;
                made[n].symbol_prob  = lead_prob;
                n++;
                // past the cap, symbols still go out but stop counting
                if (sym_count < COUNT_CAP) begin
                    prob_sum  = prob_sum + SUM_W'(lead_prob);
                    sym_count++;
                end
            end
            prev_idx  = lead_idx;
            prev_seen = 1'b1;
            class_pos = '0;
            lead_idx  = '0;
            lead_prob = '0;
            if (seq_done) begin
                made[n].kind         = KIND_SUMMARY;
                made[n].symbol_count = sym_count;
                made[n].mean_conf    = (sym_count == '0) ? '0 :
                                       PROB_W'(prob_sum / sym_count);
                n++;
                prev_seen = 1'b0;
                prev_idx  = '0;
                prob_sum  = '0;
                sym_count = '0;
            end
            if (n > 0)
                made[n-1].last = 1'b1;
            for (k = 0; k < n; k++)
                decoded_q.push_back(made[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_decoded want;
        if (!i_rst_n) begin
            blank_idx = '0;
            class_pos = '0;
            lead_idx  = '0;
            lead_prob = '0;
            prev_idx  = '0;
            prev_seen = 1'b0;
            prob_sum  = '0;
            sym_count = '0;
            decoded_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (decoded_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got kind %0d index %0d",
                             $time, i_out_mon.kind, i_out_mon.symbol_index);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", want.kind, i_out_mon.kind);
                    check_field("symbol_index", want.symbol_index, i_out_mon.symbol_index);
                    check_field("symbol_prob", want.symbol_prob, i_out_mon.symbol_prob);
                    check_field("mean_conf", want.mean_conf, i_out_mon.mean_conf);
                    check_field("symbol_count", want.symbol_count, i_out_mon.symbol_count);
                    check_field("last", want.last, i_out_mon.last);
                end
            end
            if (i_cfg_we)
                blank_idx = i_cfg_wdata;
            if (i_in_mon.valid && i_in_mon.ready)
                decode_class(i_in_mon.class_prob, i_in_mon.row_end, i_in_mon.seq_end);
        end
        o_pending <= decoded_q.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ctcg_pkg::*;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_wdata = '0;

    int pending_results;
    int fail_count;
    int items_sent  = 0;
    bit steady_send = 1'b0;  // hold valid high between transactions
    bit steady_recv = 1'b0;  // hold ready high

    ctcg_in_if  in_ch ();
    ctcg_out_if out_ch ();

    ctc_greedy_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Watch both channels and the register port; predict and compare.
    ctcg_decode_checker u_decode_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    always #4 i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Row length: mostly short rows, so repeated winners stay frequent.
    function automatic int row_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 5);
        else if (r < 97)
            return $urandom_range(6, 16);
        else
            return $urandom_range(17, 40);
    endfunction

    // Drive one class and hold it until the transaction completes.
    task automatic push_class(input logic [PROB_W-1:0] prob, input logic row_done,
                              input logic seq_done);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.class_prob <= prob;
        in_ch.row_end    <= row_done;
        in_ch.seq_end    <= seq_done;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet.
    task automatic settle();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending_results != 0 && guard < 20000);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_blank(input logic [IDX_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // One row of random content; ties, zeros and full scale come up often.
    // A stray seq_end without row_end is mixed in now and then.
    task automatic random_row(input int len, input logic close_seq);
        logic [PROB_W-1:0] p;
        logic [PROB_W-1:0] last_p;
        int                k;
        last_p = '0;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       p = '0;
                1:       p = '1;
                2, 3:    p = last_p;
                default: p = PROB_W'($urandom);
            endcase
            last_p = p;
            if (k == len - 1)
                push_class(p, 1'b1, close_seq);
            else
                push_class(p, 1'b0, $urandom_range(0, 19) == 0);
        end
    endtask

    // Mostly complete sequences; a tenth are left open and run into the next.
    task automatic random_phase(input int quota);
        int stop;
        int rows;
        int r;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            steady_send = ($urandom_range(0, 4) == 0);
            rows = $urandom_range(1, 10);
            for (r = 0; r < rows; r++)
                random_row(row_len(), (r == rows - 1) && ($urandom_range(0, 9) != 0));
        end
        steady_send = 1'b0;
    endtask

    // Receiver: stall at random, with quiet stretches of steady ready.
    initial begin : receiver
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || hold > 0) begin
                out_ch.ready <= 1'b0;
                if (hold > 0)
                    hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 255) == 0)
                    steady_recv = !steady_recv;
                if (!steady_recv && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    initial begin : stimulus
        in_ch.valid      = 1'b0;
        in_ch.class_prob = '0;
        in_ch.row_end    = 1'b0;
        in_ch.seq_end    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, blank at its reset value of 0.
        // Full-scale single-class row lands on the blank: no symbol.
        push_class(16'hFFFF, 1'b1, 1'b0);
        // Class 1 wins at full scale.
        push_class(16'h0000, 1'b0, 1'b0);
        push_class(16'hFFFF, 1'b1, 1'b0);
        // Tie between classes 1 and 2: the earlier wins, and repeats the last row.
        push_class(16'h1234, 1'b0, 1'b0);
        push_class(16'h8000, 1'b0, 1'b0);
        push_class(16'h8000, 1'b1, 1'b0);
        // Blank row in between: the same winner afterwards is emitted again.
        push_class(16'hFFFF, 1'b1, 1'b0);
        push_class(16'h0000, 1'b0, 1'b0);
        push_class(16'h0001, 1'b1, 1'b0);
        // seq_end without row_end is ignored; the row then closes the sequence.
        push_class(16'h5555, 1'b0, 1'b1);
        push_class(16'hAAAA, 1'b1, 1'b1);
        // Sequence of only a blank row: zero count, zero mean.
        push_class(16'h0000, 1'b1, 1'b1);
        // All-zero row: the first class stays best.
        push_class(16'h0000, 1'b0, 1'b0);
        push_class(16'h0000, 1'b1, 1'b0);
        // Full-scale symbol with a single-symbol summary.
        push_class(16'h7FFF, 1'b0, 1'b0);
        push_class(16'hFFFF, 1'b0, 1'b0);
        push_class(16'hFFFF, 1'b1, 1'b1);

        // Random part, over several blank settings.
        // Blank at the top index never matches a short row.
        write_blank(IDX_W'(CLASS_LIMIT - 1));
        random_phase(260);
        write_blank(IDX_W'($urandom_range(0, 3)));
        random_phase(260);
        write_blank('0);
        random_phase(260);
        write_blank(IDX_W'($urandom_range(0, CLASS_LIMIT - 1)));
        random_phase(260);
        write_blank(IDX_W'(1));
        random_phase(260);
        write_blank(IDX_W'($urandom_range(0, 7)));
        random_phase(260);

        settle();
        if (fail_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule.
    initial begin : watchdog
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
